FILE: design/aes_cenc_pkg.sv
package aes_cenc_pkg;

  localparam logic [1:0] CmdEncrypt = 2'd0;
  localparam logic [1:0] CmdNext    = 2'd1;
  localparam logic [1:0] CmdRestart = 2'd2;

  localparam logic [2:0] RegKeyHigh = 3'd0;
  localparam logic [2:0] RegKeyLow  = 3'd1;
  localparam logic [2:0] RegIvHigh  = 3'd2;
  localparam logic [2:0] RegIvLow   = 3'd3;
  localparam logic [2:0] RegIvShort = 3'd4;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    logic         block;
    logic [127:0] counter;
    logic [3:0]   pos;
    logic [7:0]   data;
  } aes_cenc_job_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte b of a block sits at bits [127-8b -: 8]
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int b);
    get_byte = s[127 - 8*b -: 8];
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
                                            input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = Sbox[get_byte(s, i + 4*((c + i) % 4))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    round_fn = o ^ rk;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    tw = {Sbox[w3[23:16]] ^ rcon, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

FILE: design/aes_cenc_front.sv
module aes_cenc_front import aes_cenc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  logic [1:0]    command_i,
  input  logic [7:0]    data_byte_i,
  input  logic [63:0]   iv_high_i,
  input  logic [63:0]   iv_low_i,
  input  logic          iv_short_i,
  output logic          job_valid_o,
  input  logic          job_stall_i,
  output aes_cenc_job_t job_o
);

  logic [63:0] ctr_hi_q, ctr_hi_d, ctr_lo_q, ctr_lo_d, siv_hi_q, siv_hi_d;
  logic [3:0]  pos_q, pos_d;
  logic        wrap_q, wrap_d;
  logic        acc, enc;

  aes_cenc_job_t q_mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign stall_o = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign acc = valid_i && !stall_o;
  assign enc = acc && (command_i == CmdEncrypt);

  always_comb begin
    ctr_hi_d = ctr_hi_q; ctr_lo_d = ctr_lo_q; siv_hi_d = siv_hi_q;
    pos_d = pos_q; wrap_d = wrap_q;
    if (acc) begin
      unique case (command_i)
        CmdEncrypt: begin
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'd0) begin
            ctr_lo_d = ctr_lo_q + 64'd1;
            if (ctr_lo_d == 64'd0) wrap_d = 1'b1;
          end
        end
        CmdNext: begin
          pos_d = 4'd0; wrap_d = 1'b0;
          if (iv_short_i) begin
            siv_hi_d = siv_hi_q + 64'd1;
            ctr_hi_d = siv_hi_d; ctr_lo_d = 64'd0;
          end else begin
            if (wrap_q) ctr_hi_d = ctr_hi_q + 64'd1;
            siv_hi_d = ctr_hi_d;
          end
        end
        CmdRestart: begin
          pos_d = 4'd0; wrap_d = 1'b0;
          siv_hi_d = iv_high_i; ctr_hi_d = iv_high_i;
          ctr_lo_d = iv_short_i ? 64'd0 : iv_low_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_hi_q <= '0; ctr_lo_q <= '0; siv_hi_q <= '0; pos_q <= '0; wrap_q <= 1'b0;
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      ctr_hi_q <= ctr_hi_d; ctr_lo_q <= ctr_lo_d; siv_hi_q <= siv_hi_d;
      pos_q <= pos_d; wrap_q <= wrap_d;
      if (enc) wr_q <= wr_q + 1'b1;
      if (job_valid_o && !job_stall_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(enc) - (QueuePtrW+1)'(job_valid_o && !job_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc) begin
      q_mem[wr_q] <= '{block: (pos_q == 4'd0), counter: {ctr_hi_q, ctr_lo_q},
                       pos: pos_q, data: data_byte_i};
    end
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o = q_mem[rd_q];

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> job_valid_o) else $error("stall while empty");
  a_pos_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && command_i == CmdRestart) |=> pos_q == 4'd0) else $error("restart pos");

endmodule

FILE: design/aes_cenc_back.sv
module aes_cenc_back import aes_cenc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_stall_o,
  input  aes_cenc_job_t job_i,
  input  logic [127:0]  key_i,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [7:0]    cipher_byte_o
);

  logic         busy_q;
  logic [3:0]   rnd_q;
  logic [127:0] st_q, rk_q, ks_q;
  logic [7:0]   rcon_q;
  logic [127:0] nk;
  logic         out_free, start, take;
  logic [7:0]   out_q;
  logic         ov_q;
  logic         blk_done_q;

  assign out_free = !ov_q || !stall_i;
  // a block job waits for the round core; byte jobs go out once the core is idle
  assign start = job_valid_i && job_i.block && !busy_q && !blk_done_q;
  assign take = job_valid_i && out_free && !busy_q && (!job_i.block || blk_done_q);
  assign job_stall_o = !take;
  assign nk = next_key(rk_q, rcon_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; rnd_q <= '0; ov_q <= 1'b0; ks_q <= '0; blk_done_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1; rnd_q <= 4'd1;
      end else if (busy_q) begin
        if (rnd_q == 4'd10) begin
          busy_q <= 1'b0;
          ks_q <= round_fn(st_q, nk, 1'b1);
        end
        rnd_q <= rnd_q + 4'd1;
      end
      // the job in the queue head keeps its block flag; this marks its keystream ready
      if (busy_q && rnd_q == 4'd10) blk_done_q <= 1'b1;
      else if (take) blk_done_q <= 1'b0;
      if (take) ov_q <= 1'b1;
      else if (!stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      st_q <= job_i.counter ^ key_i; rk_q <= key_i; rcon_q <= 8'h01;
    end else begin
      st_q <= round_fn(st_q, nk, 1'b0); rk_q <= nk; rcon_q <= xtime(rcon_q);
    end
    if (take) out_q <= job_i.data ^ get_byte(ks_q, int'(job_i.pos));
  end

  assign valid_o = ov_q;
  assign cipher_byte_o = out_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !take) else $error("output during round");
  a_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rnd_q >= 4'd1 && rnd_q <= 4'd10)) else $error("round range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && stall_i) |=> $stable(out_q)) else $error("output changed");

endmodule

FILE: design/aes_ctr_cenc_byte_encryptor.sv
// Channel   Valid     Stall     Payload
// input     valid_i   stall_o   command_i, data_byte_i
// output    valid_o   stall_i   cipher_byte_o
// One request per cycle while the job queue is not full (stall_o low).
// Bytes 1..15 of a block pass without waiting for the round core; byte 0 of a
// block waits for the iterative AES round core to compute the block's keystream.
// A 4-entry queue separates the counter front end from the round core.
// Reset is asynchronous, active low; all configuration clears to zero.
module aes_ctr_cenc_byte_encryptor import aes_cenc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  cipher_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        iv_short_q;
  logic [2:0]  idx;
  logic        jv, js;
  aes_cenc_job_t job;

  assign pready = 1'b1;
  assign idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0; iv_short_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegKeyHigh: key_hi_q <= pwdata;
        RegKeyLow:  key_lo_q <= pwdata;
        RegIvHigh:  iv_hi_q <= pwdata;
        RegIvLow:   iv_lo_q <= pwdata;
        RegIvShort: iv_short_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegKeyHigh: prdata = key_hi_q;
      RegKeyLow:  prdata = key_lo_q;
      RegIvHigh:  prdata = iv_hi_q;
      RegIvLow:   prdata = iv_lo_q;
      RegIvShort: prdata = {63'd0, iv_short_q};
      default:    prdata = '0;
    endcase
  end

  aes_cenc_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .data_byte_i,
    .iv_high_i(iv_hi_q), .iv_low_i(iv_lo_q), .iv_short_i(iv_short_q),
    .job_valid_o(jv), .job_stall_i(js), .job_o(job)
  );

  aes_cenc_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_stall_o(js), .job_i(job),
    .key_i({key_hi_q, key_lo_q}), .valid_o, .stall_i, .cipher_byte_o
  );

endmodule

FILE: sim/testbench.sv
module testbench;
  import aes_cenc_pkg::*;

  localparam logic [1:0] CmdIgnored = 2'd3;

  class cipher_scoreboard;
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         iv_sh;
    logic [127:0] ctr, sample_iv, kstream;
    logic [3:0]   pos;
    logic         wrapped;
    logic [7:0]   cipher_q[$];
    int           errors;

    function new();
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; iv_sh = 1'b0;
      ctr = '0; sample_iv = '0; kstream = '0; pos = '0; wrapped = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        RegKeyHigh: key_hi = val;
        RegKeyLow:  key_lo = val;
        RegIvHigh:  iv_hi = val;
        RegIvLow:   iv_lo = val;
        RegIvShort: iv_sh = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [127:0] block_cipher(logic [127:0] k, logic [127:0] blk);
      logic [7:0] s[16], t[16], rk[16];
      logic [7:0] rc, a0, a1, a2, a3, al, tmp;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
        rk[i] = k[127 - 8*i -: 8];
        s[i] = blk[127 - 8*i -: 8] ^ rk[i];
      end
      rc = 8'h01;
      for (int r = 1; r <= 10; r++) begin
        tmp = rk[12];
        rk[0] = rk[0] ^ Sbox[rk[13]] ^ rc;
        rk[1] = rk[1] ^ Sbox[rk[14]];
        rk[2] = rk[2] ^ Sbox[rk[15]];
        rk[3] = rk[3] ^ Sbox[tmp];
        for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
        rc = dbl(rc);
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) t[i + 4*c] = Sbox[s[i + 4*((c + i) % 4)]];
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
      return o;
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] data);
      case (cmd)
        CmdEncrypt: begin
          if (pos == 0) begin
            kstream = block_cipher({key_hi, key_lo}, ctr);
            ctr[63:0] = ctr[63:0] + 64'd1;
            if (ctr[63:0] == 64'd0) wrapped = 1'b1;
          end
          cipher_q.push_back(data ^ kstream[127 - 8*pos -: 8]);
          pos = pos + 4'd1;
        end
        CmdNext: begin
          pos = '0;
          if (iv_sh) begin
            sample_iv = {sample_iv[127:64] + 64'd1, 64'd0};
            ctr = sample_iv;
          end else begin
            if (wrapped) ctr[127:64] = ctr[127:64] + 64'd1;
            sample_iv = ctr;
          end
          wrapped = 1'b0;
        end
        CmdRestart: begin
          pos = '0;
          sample_iv = {iv_hi, iv_sh ? 64'd0 : iv_lo};
          ctr = sample_iv;
          wrapped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (cipher_q.size() == 0) begin
        report($sformatf("unexpected cipher byte %h", got));
      end else begin
        want = cipher_q.pop_front();
        if (got !== want) report($sformatf("cipher byte %h, expected %h", got, want));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  command_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [7:0]  cipher_byte_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  logic        pready;

  cipher_scoreboard sb = new();
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0, wait_left = 0;
  int cycles = 0;

  aes_ctr_cenc_byte_encryptor DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        sb.check_result(cipher_byte_o);
        wait_left = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  task write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task configure(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih, logic [63:0] il,
                 logic sh);
    write_reg(RegKeyHigh, kh);
    write_reg(RegKeyLow, kl);
    write_reg(RegIvHigh, ih);
    write_reg(RegIvLow, il);
    write_reg(RegIvShort, {63'd0, sh});
  endtask

  task send(logic [1:0] cmd, logic [7:0] data);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1; command_i <= cmd; data_byte_i <= data;
    do @(posedge clk_i); while (stall_o);
    sb.note_request(cmd, data);
  endtask

  task drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.cipher_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 86) send(CmdEncrypt, 8'($urandom_range(0, 255)));
    else if (r < 93) send(CmdNext, 8'($urandom_range(0, 255)));
    else if (r < 97) send(CmdRestart, 8'($urandom_range(0, 255)));
    else send(CmdIgnored, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero config first, then extremes
    send(CmdEncrypt, 8'h00);
    send(CmdEncrypt, 8'hff);
    drain();
    configure('1, '1, 64'h0123_4567_89ab_cdef, 64'hffff_ffff_ffff_fffe, 1'b0);
    send(CmdRestart, 8'h00);
    for (int i = 0; i < 17; i++) send(CmdEncrypt, (i % 2) ? 8'hff : 8'h00);
    send(CmdNext, 8'h00);
    send(CmdEncrypt, 8'h5a);
    send(CmdIgnored, 8'hff);
    send(CmdEncrypt, 8'ha5);
    send(CmdRestart, 8'hff);
    send(CmdEncrypt, 8'h3c);
    drain();
    // short IV at top of range: sample IV wraps
    configure('0, 64'h8000_0000_0000_0001, '1, '1, 1'b1);
    send(CmdRestart, 8'h00);
    send(CmdEncrypt, 8'h11);
    send(CmdNext, 8'h00);
    send(CmdEncrypt, 8'h22);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(rand64(), rand64(), rand64(), 64'hffff_ffff_ffff_ffd0, 1'b0);
        1: configure('1, '0, '1, '1, 1'b1);
        2: configure(rand64(), rand64(), rand64(), rand64(), 1'b0);
        3: configure(rand64(), rand64(), '0, '0, 1'b1);
        4: configure('0, '0, rand64(), 64'hffff_ffff_ffff_ffff, 1'b0);
        default: configure(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
      endcase
      no_gaps = (ph == 1 || ph == 4);
      send(CmdRestart, 8'($urandom_range(0, 255)));
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < 130; n++) begin
        if (ph == 3 && n == 60) begin
          valid_i <= 1'b0;
          @(posedge clk_i);
          while (sb.cipher_q.size() != 0) @(posedge clk_i);
        end
        random_item();
      end
      no_gaps = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.cipher_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
